/* hdl/civil_datetime_to_epoch_seconds_assert.svh */
// Assertion macros for the civil date to epoch seconds block
`ifndef CIVIL_DATETIME_TO_EPOCH_SECONDS_ASSERT_SVH
`define CIVIL_DATETIME_TO_EPOCH_SECONDS_ASSERT_SVH

// Same-cycle implication under reset
`define CDTE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under reset
`define CDTE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/cdte_pkg.sv */
// Shared types, constants and helper functions for the epoch seconds converter
package cdte_pkg;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_DATE  = 2'd1,
        STAT_TIME  = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int OFFSET_W = 18;
    localparam int EPOCH_W  = 39;
    localparam int DAYS_W   = 24;
    localparam int TSEC_W   = 19;
    localparam int SECS_W   = 42;

    localparam int YEAR_BIAS   = 400;
    localparam int DAYS_BIAS   = 865565;
    localparam int OFFSET_LIM  = 86399;
    localparam int SECS_PER_DAY = 86400;

    localparam logic signed [SECS_W-1:0] EPOCH_MIN = -42'sd62167219200;
    localparam logic signed [SECS_W-1:0] EPOCH_MAX = 42'sd253402300799;

    localparam logic [12:0] RECIP25 = 13'd5243;

    typedef logic signed [DAYS_W-1:0] days_t;

    function automatic logic [9:0] div25(input logic [13:0] x);
        logic [26:0] p;
        p = 27'(x) * 27'(RECIP25);
        return p[26:17];
    endfunction

    function automatic logic [8:0] doy_base(input logic [3:0] m);
        logic [8:0] b;
        case (m)
            4'd3:    b = 9'd0;
            4'd4:    b = 9'd31;
            4'd5:    b = 9'd61;
            4'd6:    b = 9'd92;
            4'd7:    b = 9'd122;
            4'd8:    b = 9'd153;
            4'd9:    b = 9'd184;
            4'd10:   b = 9'd214;
            4'd11:   b = 9'd245;
            4'd12:   b = 9'd275;
            4'd1:    b = 9'd306;
            4'd2:    b = 9'd337;
            default: b = 9'd0;
        endcase
        return b;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] n;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   n = 5'd30;
            4'd2:                                      n = leap ? 5'd29 : 5'd28;
            default:                                   n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

/* hdl/cdte_days.sv */
// Three-stage day count and date check for the epoch seconds converter
module cdte_days
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic [cdte_pkg::YEAR_W-1:0]    year,
    input  logic [cdte_pkg::MONTH_W-1:0]   month,
    input  logic [cdte_pkg::DAY_W-1:0]     day,
    output cdte_pkg::days_t                days,
    output logic                           bad_date
);
    import cdte_pkg::*;

    logic [YEAR_W-1:0]  year1_reg, year1_next;
    logic [MONTH_W-1:0] month1_reg;
    logic [DAY_W-1:0]   day1_reg;
    logic [14:0]        a1_reg, a1_next;
    logic [9:0]         q25_1_reg, q25_1_next;
    logic [8:0]         doy1_reg, doy1_next;

    logic [12:0]        a4_2_reg;
    logic [9:0]         q100_2_reg, q100_2_next;
    logic [9:0]         q400_2_reg, q400_2_next;
    logic [22:0]        y365_2_reg, y365_2_next;
    logic [8:0]         doy2_reg;
    logic               bad2_reg, bad2_next;

    days_t              days3_reg, days3_next;
    logic               bad3_reg;

    logic               leap2;
    logic [4:0]         len2;
    logic [14:0]        y25;
    logic [24:0]        sum3;

    assign year1_next = year;

    always_comb
    begin
        a1_next    = 15'(year) + 15'(YEAR_BIAS) - ((month inside {[4'd0:4'd2]}) ? 15'd1 : 15'd0);
        q25_1_next = div25(year);
        doy1_next  = doy_base(month) + 9'(day) - 9'd1;
    end

    always_comb
    begin
        y25         = 15'(q25_1_reg) * 15'd25;
        leap2       = (year1_reg[1:0] == 2'd0) &&
                      ((15'(year1_reg) != y25) || (year1_reg[3:0] == 4'd0));
        len2        = month_len(month1_reg, leap2);
        bad2_next   = !(month1_reg inside {[4'd1:4'd12]}) || (day1_reg == 5'd0) ||
                      (day1_reg > len2);
        q100_2_next = div25(14'(a1_reg[14:2]));
        q400_2_next = div25(14'(a1_reg[14:4]));
        y365_2_next = 23'(a1_reg) * 23'd365;
    end

    always_comb
    begin
        sum3 = 25'(y365_2_reg) + 25'(a4_2_reg) - 25'(q100_2_reg) + 25'(q400_2_reg) +
               25'(doy2_reg) - 25'(DAYS_BIAS);
        days3_next = sum3[DAYS_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            year1_reg  <= year1_next;
            month1_reg <= month;
            day1_reg   <= day;
            a1_reg     <= a1_next;
            q25_1_reg  <= q25_1_next;
            doy1_reg   <= doy1_next;

            a4_2_reg   <= a1_reg[14:2];
            q100_2_reg <= q100_2_next;
            q400_2_reg <= q400_2_next;
            y365_2_reg <= y365_2_next;
            doy2_reg   <= doy1_reg;

            days3_reg  <= days3_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bad2_reg <= 1'b0;
            bad3_reg <= 1'b0;
        end
        else if (en)
        begin
            bad2_reg <= bad2_next;
            bad3_reg <= bad2_reg;
        end
    end

    assign days     = days3_reg;
    assign bad_date = bad3_reg;

endmodule

/* hdl/civil_datetime_to_epoch_seconds.sv */
// Civil date and time with UTC offset to signed Unix seconds, top level
// Takes one beat per cycle; each result passes through the five register
// stages of the day count, the day-to-seconds multiply and the range
// check. Results come out in input order, one per beat. While the output
// beat is stalled the whole pipeline holds.
`include "civil_datetime_to_epoch_seconds_assert.svh"

module civil_datetime_to_epoch_seconds
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [cdte_pkg::YEAR_W-1:0]            year,
    input  logic [cdte_pkg::MONTH_W-1:0]           month,
    input  logic [cdte_pkg::DAY_W-1:0]             day,
    input  logic [cdte_pkg::HOUR_W-1:0]            hour,
    input  logic [cdte_pkg::MINUTE_W-1:0]          minute,
    input  logic [cdte_pkg::SECOND_W-1:0]          second,
    input  logic signed [cdte_pkg::OFFSET_W-1:0]   offset,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [cdte_pkg::EPOCH_W-1:0]    epoch_seconds,
    output logic [1:0]                             status
);
    import cdte_pkg::*;

    logic                       en;
    logic [3:0]                 v_reg;
    logic                       out_valid_reg;

    logic [16:0]                tod1_reg, tod1_next;
    logic signed [OFFSET_W-1:0] off1_reg;
    logic                       badt1_reg, badt1_next;
    logic signed [TSEC_W-1:0]   tsec2_reg, tsec2_next;
    logic signed [TSEC_W-1:0]   tsec3_reg;
    logic [2:0]                 badt_reg;
    logic signed [SECS_W-1:0]   secs4_reg, secs4_next;
    logic                       badd4_reg;

    days_t                      days3;
    logic                       bad_date3;

    status_t                    status_reg, status_next;
    logic signed [EPOCH_W-1:0]  epoch_reg, epoch_next;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    cdte_days u_days
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .year     (year),
        .month    (month),
        .day      (day),
        .days     (days3),
        .bad_date (bad_date3)
    );

    always_comb
    begin
        tod1_next  = 17'(hour) * 17'd3600 + 17'(minute) * 17'd60 + 17'(second);
        badt1_next = (hour > 5'd23) || (minute > 6'd59) || (second > 6'd59) ||
                     (offset < -18'sd86399) || (offset > 18'sd86399);
        tsec2_next = $signed({2'b00, tod1_reg}) - TSEC_W'(off1_reg);
        secs4_next = SECS_W'(days3) * 42'sd86400 + SECS_W'(tsec3_reg);
    end

    always_comb
    begin
        status_next = STAT_OK;
        epoch_next  = '0;
        if (badd4_reg)
            status_next = STAT_DATE;
        else if (badt_reg[2])
            status_next = STAT_TIME;
        else if ((secs4_reg < EPOCH_MIN) || (secs4_reg > EPOCH_MAX))
            status_next = STAT_RANGE;
        else
            epoch_next = secs4_reg[EPOCH_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tod1_reg   <= tod1_next;
            off1_reg   <= offset;
            tsec2_reg  <= tsec2_next;
            tsec3_reg  <= tsec2_reg;
            secs4_reg  <= secs4_next;
            epoch_reg  <= epoch_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
            badt1_reg     <= 1'b0;
            badt_reg      <= '0;
            badd4_reg     <= 1'b0;
            status_reg    <= STAT_OK;
        end
        else if (en)
        begin
            v_reg         <= {v_reg[2:0], in_valid};
            out_valid_reg <= v_reg[3];
            badt1_reg     <= badt1_next;
            badt_reg      <= {badt_reg[1:0], badt1_reg};
            badd4_reg     <= bad_date3;
            status_reg    <= status_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign epoch_seconds = epoch_reg;
    assign status        = status_reg;

    `CDTE_ASSERT_NOW(a_zero_on_error, out_valid_reg && (status_reg != STAT_OK), epoch_reg == '0, "nonzero seconds with error status")
    `CDTE_ASSERT_NOW(a_ok_in_range, out_valid_reg && (status_reg == STAT_OK), (SECS_W'(epoch_reg) >= EPOCH_MIN) && (SECS_W'(epoch_reg) <= EPOCH_MAX), "ok result outside year range")
    `CDTE_ASSERT_NEXT(a_last_stage_lands, v_reg[3] && en, out_valid_reg, "beat lost before output stage")

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the civil date and time to Unix seconds converter
module tb_top;
    import cdte_pkg::*;

    localparam int     CYCLE_LIMIT   = 200000;
    localparam int     TAIL_CYCLES   = 12;
    localparam int     OFFSET_MAX    = 86399;
    localparam longint UNIX_EARLIEST = -64'sd62167219200;
    localparam longint UNIX_LATEST   = 64'sd253402300799;

    typedef struct packed {
        logic [YEAR_W-1:0]          year;
        logic [MONTH_W-1:0]         month;
        logic [DAY_W-1:0]           day;
        logic [HOUR_W-1:0]          hour;
        logic [MINUTE_W-1:0]        minute;
        logic [SECOND_W-1:0]        second;
        logic signed [OFFSET_W-1:0] offset;
    } civil_stamp_t;

    typedef struct packed {
        logic signed [EPOCH_W-1:0] secs;
        status_t                   stat;
    } unix_result_t;

    logic                        clk      = 1'b0;
    logic                        rst_n    = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [YEAR_W-1:0]           year     = '0;
    logic [MONTH_W-1:0]          month    = '0;
    logic [DAY_W-1:0]            day      = '0;
    logic [HOUR_W-1:0]           hour     = '0;
    logic [MINUTE_W-1:0]         minute   = '0;
    logic [SECOND_W-1:0]         second   = '0;
    logic signed [OFFSET_W-1:0]  offset   = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic signed [EPOCH_W-1:0]   epoch_seconds;
    logic [1:0]                  status;

    unix_result_t unix_expected[$];
    unix_result_t unix_head;
    int           mismatch_count = 0;
    int           items_sent     = 0;
    int           results_seen   = 0;
    int           status_seen[4] = '{0, 0, 0, 0};
    int           cycle_count    = 0;
    bit           idle_on        = 1'b1;
    int           hold_pending   = 0;
    int           hold_left      = 0;
    int           stall_left     = 0;

    civil_datetime_to_epoch_seconds u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .year          (year),
        .month         (month),
        .day           (day),
        .hour          (hour),
        .minute        (minute),
        .second        (second),
        .offset        (offset),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .epoch_seconds (epoch_seconds),
        .status        (status)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int month_days(input longint y, input longint m);
        bit leap_year;
        leap_year = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap_year ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic unix_result_t civil_to_unix(input civil_stamp_t s);
        unix_result_t r;
        longint y, m, d, off, ay, era, yoe, mp, doy, doe, secs;
        y   = longint'(s.year);
        m   = longint'(s.month);
        d   = longint'(s.day);
        off = longint'(s.offset);
        r.secs = '0;
        r.stat = STAT_OK;
        if (m < 1 || m > 12 || d < 1 || d > month_days(y, m))
        begin
            r.stat = STAT_DATE;
        end
        else if (s.hour > 23 || s.minute > 59 || s.second > 59 ||
                 off < -OFFSET_MAX || off > OFFSET_MAX)
        begin
            r.stat = STAT_TIME;
        end
        else
        begin
            ay   = y - ((m <= 2) ? 1 : 0);
            era  = (ay >= 0) ? (ay / 400) : ((ay - 399) / 400);
            yoe  = ay - era * 400;
            mp   = (m > 2) ? (m - 3) : (m + 9);
            doy  = (153 * mp + 2) / 5 + d - 1;
            doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            secs = (era * 146097 + doe - 719468) * 86400 +
                   longint'(s.hour) * 3600 + longint'(s.minute) * 60 +
                   longint'(s.second) - off;
            if (secs < UNIX_EARLIEST || secs > UNIX_LATEST)
                r.stat = STAT_RANGE;
            else
                r.secs = secs[EPOCH_W-1:0];
        end
        return r;
    endfunction

    function automatic civil_stamp_t make_stamp(input int y, input int m, input int d,
                                                input int h, input int mi, input int s,
                                                input int off);
        civil_stamp_t c;
        c.year   = y[YEAR_W-1:0];
        c.month  = m[MONTH_W-1:0];
        c.day    = d[DAY_W-1:0];
        c.hour   = h[HOUR_W-1:0];
        c.minute = mi[MINUTE_W-1:0];
        c.second = s[SECOND_W-1:0];
        c.offset = off[OFFSET_W-1:0];
        return c;
    endfunction

    function automatic civil_stamp_t random_stamp();
        civil_stamp_t c;
        int y, m, d, len, off, pick, span;
        span = $urandom_range(0, 19);
        if (span == 0)
            y = $urandom_range(0, 1) ? 9999 : 0;
        else if (span == 1)
            y = $urandom_range(10000, 16383);
        else
            y = $urandom_range(0, 9999);
        m = $urandom_range(1, 12);
        d = $urandom_range(1, month_days(y, m));
        if (span == 0)
        begin
            m = (y == 0) ? 1 : 12;
            d = (y == 0) ? 1 : 31;
        end
        off = int'($urandom_range(0, 2 * OFFSET_MAX)) - OFFSET_MAX;
        c = make_stamp(y, m, d, $urandom_range(0, 23), $urandom_range(0, 59),
                       $urandom_range(0, 59), off);
        pick = $urandom_range(0, 99);
        if (pick >= 65 && pick < 75)
        begin
            len = month_days(y, m);
            case ($urandom_range(0, 3))
                0:       c.month = '0;
                1:       c.month = MONTH_W'($urandom_range(13, 15));
                2:       c.day = '0;
                default: c.day = (len < 31) ? DAY_W'($urandom_range(len + 1, 31)) : '0;
            endcase
        end
        else if (pick >= 75 && pick < 85)
        begin
            case ($urandom_range(0, 3))
                0:       c.hour = HOUR_W'($urandom_range(24, 31));
                1:       c.minute = MINUTE_W'($urandom_range(60, 63));
                2:       c.second = SECOND_W'($urandom_range(60, 63));
                default:
                begin
                    off = $urandom_range(OFFSET_MAX + 1, 131072);
                    c.offset = OFFSET_W'($urandom_range(0, 1) ? -off : off);
                end
            endcase
        end
        else if (pick >= 85)
        begin
            c = civil_stamp_t'({$urandom, $urandom});
        end
        return c;
    endfunction

    task automatic log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endtask

    task automatic send_stamp(input civil_stamp_t s);
        int gap;
        gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        year     <= s.year;
        month    <= s.month;
        day      <= s.day;
        hour     <= s.hour;
        minute   <= s.minute;
        second   <= s.second;
        offset   <= s.offset;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        unix_expected.push_back(civil_to_unix(s));
        items_sent++;
    endtask

    task automatic pause_until_drained();
        in_valid <= 1'b0;
        while (unix_expected.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_range_limits();
        send_stamp(make_stamp(1970, 1, 1, 0, 0, 0, 0));
        send_stamp(make_stamp(0, 1, 1, 0, 0, 0, 0));
        send_stamp(make_stamp(9999, 12, 31, 23, 59, 59, 0));
        send_stamp(make_stamp(0, 1, 1, 0, 0, 0, 1));
        send_stamp(make_stamp(9999, 12, 31, 23, 59, 59, -1));
        send_stamp(make_stamp(0, 1, 1, 0, 0, 0, -OFFSET_MAX));
        send_stamp(make_stamp(9999, 12, 31, 23, 59, 59, OFFSET_MAX));
        send_stamp(make_stamp(10000, 1, 1, 0, 0, 0, 0));
        send_stamp(make_stamp(16383, 12, 31, 23, 59, 59, -OFFSET_MAX));
    endtask

    task automatic test_calendar_checks();
        send_stamp(make_stamp(2000, 2, 29, 12, 0, 0, 0));
        send_stamp(make_stamp(1900, 2, 29, 12, 0, 0, 0));
        send_stamp(make_stamp(2023, 2, 29, 12, 0, 0, 0));
        send_stamp(make_stamp(0, 2, 29, 0, 0, 0, 0));
        send_stamp(make_stamp(2023, 0, 1, 31, 0, 0, 0));
        send_stamp(make_stamp(2023, 13, 1, 0, 0, 0, 0));
        send_stamp(make_stamp(16383, 15, 31, 31, 63, 63, -1));
        send_stamp(make_stamp(2023, 1, 0, 0, 0, 0, 0));
        send_stamp(make_stamp(2023, 4, 31, 0, 0, 0, 0));
        send_stamp(make_stamp(2023, 1, 31, 23, 59, 59, 0));
    endtask

    task automatic test_time_checks();
        send_stamp(make_stamp(2023, 6, 15, 24, 0, 0, 0));
        send_stamp(make_stamp(2023, 6, 15, 0, 60, 0, 0));
        send_stamp(make_stamp(2023, 6, 15, 0, 0, 63, 0));
        send_stamp(make_stamp(2023, 6, 15, 0, 0, 0, OFFSET_MAX + 1));
        send_stamp(make_stamp(2023, 6, 15, 0, 0, 0, -131072));
        send_stamp(make_stamp(2023, 6, 15, 0, 0, 0, 131071));
    endtask

    task automatic test_output_hold_off();
        hold_pending = 80;
        repeat (40)
            send_stamp(random_stamp());
        pause_until_drained();
    endtask

    task automatic test_random_mix(input int count);
        repeat (count)
            send_stamp(random_stamp());
    endtask

    task automatic test_back_to_back(input int count);
        idle_on = 1'b0;
        repeat (count)
            send_stamp(random_stamp());
    endtask

    always @(posedge clk)
    begin
        if (hold_pending > 0)
        begin
            hold_left    = hold_pending;
            hold_pending = 0;
        end
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 3);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            status_seen[status]++;
            if (unix_expected.size() == 0)
            begin
                log_mismatch($sformatf("unexpected beat: epoch_seconds=%0d status=%0d",
                                       epoch_seconds, status));
            end
            else
            begin
                unix_head = unix_expected.pop_front();
                if (epoch_seconds !== unix_head.secs)
                    log_mismatch($sformatf("epoch_seconds: expected %0d, got %0d",
                                           unix_head.secs, epoch_seconds));
                if (status !== unix_head.stat)
                    log_mismatch($sformatf("status: expected %s, got %0d",
                                           unix_head.stat.name(), status));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_range_limits();
        test_calendar_checks();
        test_time_checks();
        test_output_hold_off();
        test_random_mix(1700);
        test_back_to_back(300);
        pause_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (unix_expected.size() != 0)
            log_mismatch($sformatf("%0d results never arrived", unix_expected.size()));
        $display("Converted %0d timestamps into %0d results: %0d ok, %0d bad date, %0d bad time",
                 items_sent, results_seen, status_seen[STAT_OK], status_seen[STAT_DATE],
                 status_seen[STAT_TIME]);
        $display("%0d out of range; covered range limits, leap rules, long output hold-off, %s",
                 status_seen[STAT_RANGE], "random stalls and a back-to-back tail");
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
